/* rtl/plc_pkg.sv */
// Package for the positional list block: sizes, request and status codes,
// request/response payload structs and the cell control struct.
// No dependencies.
package plc_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 32;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_DELETE  = 2'd1;
  localparam logic [1:0] REQ_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [IDX_W-1:0]        at;
    logic [IDX_W-1:0]        last_idx;
    logic signed [VAL_W-1:0] value;
  } ctl_t;

endpackage

/* rtl/plc_cell.sv */
// One storage cell of the list chain: holds one entry and loads from its
// left or right neighbor, the new value or the head entry.
// Depends on plc_pkg.
module plc_cell (
  input  logic                            clk_i,
  input  logic [plc_pkg::IDX_W-1:0]       idx_i,
  input  plc_pkg::ctl_t                   ctl_i,
  input  logic signed [plc_pkg::VAL_W-1:0] left_i,
  input  logic signed [plc_pkg::VAL_W-1:0] right_i,
  input  logic signed [plc_pkg::VAL_W-1:0] head_i,
  output logic signed [plc_pkg::VAL_W-1:0] data_o
);
  import plc_pkg::*;

  logic signed [VAL_W-1:0] data_q;
  logic signed [VAL_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (idx_i > ctl_i.at) begin
          data_d = left_i;
        end else if (idx_i == ctl_i.at) begin
          data_d = ctl_i.value;
        end
      end
      CELL_DEL: begin
        if (idx_i >= ctl_i.at) begin
          data_d = right_i;
        end
      end
      CELL_ROT: begin
        if (idx_i == ctl_i.last_idx) begin
          data_d = head_i;
        end else if (idx_i < ctl_i.last_idx) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/positional_list_insert_delete_top.sv */
// Top level of the positional list: request handling, count, display
// sequencing and the row of storage cells.
// Depends on plc_pkg and plc_cell.
//
// Usage: requests enter on in_valid_i/in_stall_o with an insert, delete or
// display code, a value and a 1-based position. Responses leave on
// out_valid_o/out_stall_i from an output register.
// Insert and delete take effect at the edge that accepts the request and
// give one response in the next cycle, so one request per cycle is
// sustained while the receiver keeps up. A display of N entries gives N
// responses, one per cycle while the receiver keeps up, by rotating the
// cell row once around: the block enters its display state, each step
// loads the head entry into the output register, and the next request is
// taken once the last has been loaded and the block is idle again. An
// empty display gives one underflow response in the next cycle.
// When the receiver stalls, the output register holds its response and the
// block stalls new requests and the display rotation until it is taken.
// Reset empties the list and clears any pending response; cell contents
// are not cleared and are never read before they are written.
module positional_list_insert_delete_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plc_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plc_pkg::rsp_t  out_rsp_o
);
  import plc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] remain_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic                    out_free;
  logic                    in_fire;
  logic                    disp_fire;
  logic                    full;
  logic [POS_W-1:0]        cnt_pos;
  logic [IDX_W-1:0]        slot;
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        at_ins;
  logic [IDX_W-1:0]        at_del;
  ctl_t                    ctl;
  logic signed [VAL_W-1:0] data_w [DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign disp_fire  = (state_q == S_DISP) && out_free;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign cnt_pos  = POS_W'(count_q);
  assign slot     = (in_req_i.position == '0) ? '0
                  : IDX_W'(in_req_i.position - POS_W'(1));
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign at_ins   = ((count_q == '0) || (in_req_i.position > cnt_pos))
                  ? IDX_W'(count_q) : slot;
  assign at_del   = (in_req_i.position >= cnt_pos) ? last_idx : slot;

  always_comb begin
    ctl.op       = CELL_HOLD;
    ctl.at       = at_ins;
    ctl.last_idx = last_idx;
    ctl.value    = in_req_i.value;
    if (disp_fire) begin
      ctl.op = CELL_ROT;
    end else if (in_fire) begin
      case (in_req_i.req_type)
        REQ_INSERT: begin
          if (!full) begin
            ctl.op = CELL_INS;
          end
        end
        REQ_DELETE: begin
          if (count_q != '0) begin
            ctl.op = CELL_DEL;
            ctl.at = at_del;
          end
        end
        default: begin
          ctl.op = CELL_HOLD;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = data_w[i];
    end else begin : g_left
      assign left_w = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = data_w[i];
    end else begin : g_right
      assign right_w = data_w[i+1];
    end
    plc_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (data_w[0]),
      .data_o (data_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (disp_fire) begin
        out_valid_q       <= 1'b1;
        out_q.status      <= ST_OK;
        out_q.entry_value <= data_w[0];
        out_q.last        <= (remain_q == CNT_W'(1));
        remain_q          <= remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          state_q <= S_IDLE;
        end
      end else if (in_fire) begin
        out_q.status      <= ST_OK;
        out_q.entry_value <= '0;
        out_q.last        <= 1'b1;
        out_valid_q       <= 1'b1;
        case (in_req_i.req_type)
          REQ_INSERT: begin
            if (full) begin
              out_q.status <= ST_OVER;
            end else begin
              count_q <= count_q + CNT_W'(1);
            end
          end
          REQ_DELETE: begin
            if (count_q == '0) begin
              out_q.status <= ST_UNDER;
            end else begin
              count_q <= count_q - CNT_W'(1);
            end
          end
          REQ_DISPLAY: begin
            if (count_q == '0) begin
              out_q.status <= ST_UNDER;
            end else begin
              out_valid_q <= 1'b0;
              remain_q    <= count_q;
              state_q     <= S_DISP;
            end
          end
          default: begin
            out_q.status <= ST_OK;
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list count exceeds depth");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.req_type == REQ_INSERT && full)
    |=> (full && out_valid_o && out_rsp_o.status == ST_OVER))
    else $error("insert into full list not reported as overflow");

  a_disp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disp_fire && remain_q == CNT_W'(1))
    |=> (state_q == S_IDLE && out_valid_o && out_rsp_o.last))
    else $error("display did not end on its final entry");

  a_disp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |-> (remain_q != '0 && $stable(count_q)))
    else $error("display sequencing lost track of the list");

endmodule

/* tb/positional_list_checker.sv */
// Checker for the positional list block: keeps a shadow copy of the list,
// predicts the responses of every accepted request and compares them in order.
// Depends on plc_pkg for the request and response types and codes.
module positional_list_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  plc_pkg::req_t in_req_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  plc_pkg::rsp_t out_rsp_i,
  output int unsigned   pending_o,
  output int unsigned   fail_count_o
);
  import plc_pkg::*;

  logic signed [VAL_W-1:0] list_entries[$];
  rsp_t                    expected_rsps[$];
  int unsigned             fail_total;

  function automatic rsp_t single_rsp(input logic [1:0] status);
    rsp_t r;
    r.status      = status;
    r.entry_value = '0;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void predict_request(input req_t r);
    int unsigned n;
    int unsigned at;
    rsp_t        e;
    n = list_entries.size();
    case (r.req_type)
      REQ_INSERT: begin
        if (n >= DEPTH) begin
          expected_rsps.push_back(single_rsp(ST_OVER));
        end else begin
          if (n == 0 || r.position > n) at = n;
          else at = (r.position == 0) ? 0 : r.position - 1;
          list_entries.insert(at, r.value);
          expected_rsps.push_back(single_rsp(ST_OK));
        end
      end
      REQ_DELETE: begin
        if (n == 0) begin
          expected_rsps.push_back(single_rsp(ST_UNDER));
        end else begin
          if (r.position >= n) at = n - 1;
          else at = (r.position == 0) ? 0 : r.position - 1;
          list_entries.delete(at);
          expected_rsps.push_back(single_rsp(ST_OK));
        end
      end
      REQ_DISPLAY: begin
        if (n == 0) begin
          expected_rsps.push_back(single_rsp(ST_UNDER));
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            e.status      = ST_OK;
            e.entry_value = list_entries[i];
            e.last        = (i == n - 1);
            expected_rsps.push_back(e);
          end
        end
      end
      default: begin
        expected_rsps.push_back(single_rsp(ST_OK));
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      list_entries.delete();
      expected_rsps.delete();
      fail_total = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: status %0d entry_value %0d last %0d",
                 out_rsp_i.status, out_rsp_i.entry_value, out_rsp_i.last);
          fail_total++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_rsp_i.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_rsp_i.status);
            fail_total++;
          end
          if (out_rsp_i.entry_value !== e.entry_value) begin
            $error("entry_value: expected %0d, actual %0d",
                   e.entry_value, out_rsp_i.entry_value);
            fail_total++;
          end
          if (out_rsp_i.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, out_rsp_i.last);
            fail_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(in_req_i);
      end
    end
    pending_o    <= expected_rsps.size();
    fail_count_o <= fail_total;
  end

endmodule

/* tb/tb_positional_list_insert_delete_top.sv */
// Testbench top for the positional list block: clock, reset, directed and
// random request streams with random stalls on both sides, and the verdict.
// Depends on plc_pkg, positional_list_insert_delete_top and positional_list_checker.
module tb_positional_list_insert_delete_top;
  import plc_pkg::*;

  localparam logic [1:0]  REQ_UNUSED      = 2'd3;
  localparam int unsigned RUN_LIMIT       = 300000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS     = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rsp_t        out_rsp_o;
  int unsigned pending_rsps;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  bit          hold_off_pending = 1'b0;

  positional_list_insert_delete_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  positional_list_checker list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_i    (out_rsp_o),
    .pending_o    (pending_rsps),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, or for one long stretch when asked.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  function automatic req_t make_req(input logic [1:0] kind,
                                    input logic signed [VAL_W-1:0] val,
                                    input logic [POS_W-1:0] pos);
    req_t r;
    r.req_type = kind;
    r.value    = val;
    r.position = pos;
    return r;
  endfunction

  function automatic req_t random_req(input bit grow);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) r.req_type = REQ_UNUSED;
    else if (pick < 20) r.req_type = REQ_DISPLAY;
    else if (pick < (grow ? 80 : 40)) r.req_type = REQ_INSERT;
    else r.req_type = REQ_DELETE;
    r.value    = $urandom;
    r.position = ($urandom_range(99) < 85) ? POS_W'($urandom_range(0, 20))
                                           : POS_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_req(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list cases, then edge values and positions on a short list.
    send_req(make_req(REQ_DISPLAY, 32'h0, 8'd1));
    send_req(make_req(REQ_DELETE, 32'h0, 8'd0));
    send_req(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 8'd255));
    send_req(make_req(REQ_INSERT, 32'h7FFF_FFFF, 8'd0));
    send_req(make_req(REQ_INSERT, 32'h8000_0000, 8'd255));
    send_req(make_req(REQ_INSERT, 32'hFFFF_FFFF, 8'd2));
    send_req(make_req(REQ_DISPLAY, 32'h0, 8'd0));
    send_req(make_req(REQ_DELETE, 32'h0, 8'd2));
    send_req(make_req(REQ_DELETE, 32'h0, 8'd0));
    send_req(make_req(REQ_DELETE, 32'h0, 8'd200));
    send_req(make_req(REQ_DISPLAY, 32'h0, 8'd3));
    // Fill the list, overflow it and show it whole.
    for (int k = 0; k < DEPTH; k++) begin
      send_req(make_req(REQ_INSERT, $urandom, POS_W'($urandom_range(0, k + 1))));
    end
    send_req(make_req(REQ_INSERT, 32'h1234_5678, 8'd1));
    send_req(make_req(REQ_DISPLAY, 32'h0, 8'd255));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          rcv_idle_pct  = 46;
        end
        1: begin
          send_idle_pct = 46;
          rcv_idle_pct  = 35;
        end
        default: begin
          send_idle_pct    = 0;
          rcv_idle_pct     = 0;
          hold_off_pending = 1'b1;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_req(random_req(((i / 30) % 2) == 0));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/plc_pkg.sv
rtl/plc_cell.sv
rtl/positional_list_insert_delete_top.sv
tb/positional_list_checker.sv
tb/tb_positional_list_insert_delete_top.sv
